@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define BBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define BBA_IMPLY(lbl, ante, cons) \
  `BBA_ASSERT(lbl, (ante) |-> (cons))

// Next-cycle implication.
`define BBA_NEXT(lbl, ante, cons) \
  `BBA_ASSERT(lbl, (ante) |=> (cons))

`endif

@@ rtl/core/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned MAX_BLOCKS = 64;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned DIV_CNT_W  = $clog2(ADDR_W);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NOTUSED = 2'd3
  } bba_status_e;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] free_address;
  } bba_in_t;

  typedef struct packed {
    logic              ok;
    bba_status_e       status;
    logic [ADDR_W-1:0] block_address;
    logic [IDX_W-1:0]  block_index;
    logic [CNT_W-1:0]  blocks_free;
  } bba_out_t;

endpackage

@@ rtl/core/bba_div.sv @@
// ----------------------------------------------------------------------------
// bba_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bba_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bba_pkg::ADDR_W-1:0] dividend_i,
  input  logic [bba_pkg::SIZE_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [bba_pkg::ADDR_W-1:0] quotient_o
);
  import bba_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0]    dq_q, dq_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [SIZE_W-1:0]    dvs_q, dvs_d;
  logic [SIZE_W:0]      rem_sh;
  logic                 take;

  assign rem_sh = {rem_q, dq_q[ADDR_W-1]};
  assign take   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = {dq_q[ADDR_W-2:0], take};
      rem_d = take ? SIZE_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[SIZE_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(ADDR_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

@@ rtl/core/bitmap_block_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Fixed-size block allocator with a used-mark bitmap held in a 1-bit memory.
// ----------------------------------------------------------------------------
// One request is in work at a time. An allocate walks the used map through
// the memory read port, one entry per cycle, until it finds a free entry or
// reaches the effective block count (pool full). A free runs the address
// offset through a 32-step serial divider, then reads one map entry and
// clears it if it was in use. An allocate on an empty pool or a free below
// pool_base goes straight to the response state. The next request word can
// be taken in the same cycle that a result word is first offered. After
// reset, and after every write of block_size or block_count, a clearing pass
// sweeps all MAX_BLOCKS map entries while no request word is taken;
// configuration writes are taken at any time but belong to idle periods.
// The result register lets a new request start while the previous result
// word still waits on the output.
`include "assert_macros.svh"

module bitmap_block_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bba_pkg::bba_in_t              in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bba_pkg::bba_out_t             out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bba_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_RESP  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [SIZE_W-1:0] block_size_q, block_size_d;
  logic [CNT_W-1:0]  block_count_q, block_count_d;
  logic [ADDR_W-1:0] pool_base_q, pool_base_d;
  logic [CNT_W-1:0]  eff_n;
  logic [SIZE_W-1:0] eff_size;
  logic [CNT_W-1:0]  new_count;

  // allocator state
  logic [CNT_W-1:0]  free_count_q, free_count_d;
  logic [IDX_W-1:0]  clr_idx_q, clr_idx_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;
  logic              chk_vld_q, chk_vld_d;
  logic [ADDR_W-1:0] acc_addr_q, acc_addr_d;
  logic [IDX_W-1:0]  q_idx_q, q_idx_d;

  // pending result
  bba_status_e       res_status_q, res_status_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;

  logic              out_valid_q, out_valid_d;
  bba_out_t          out_q, out_d;

  // map memory
  logic              map_q [MAX_BLOCKS];
  logic              map_rdata_q;
  logic              map_we;
  logic [IDX_W-1:0]  map_waddr;
  logic              map_wdata;
  logic [IDX_W-1:0]  map_raddr;

  // divider
  logic              div_start;
  logic [ADDR_W-1:0] div_dividend;
  logic              div_done;
  logic [ADDR_W-1:0] div_quot;

  logic in_fire, cfg_fire, out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign eff_n    = (block_count_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : block_count_q;
  assign eff_size = (block_size_q == '0) ? SIZE_W'(1) : block_size_q;

  assign div_dividend = in_i.free_address - pool_base_q;
  assign map_raddr    = (state_q == S_SCAN) ? rd_idx_q[IDX_W-1:0] : div_quot[IDX_W-1:0];

  bba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (eff_size),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    block_size_d  = block_size_q;
    block_count_d = block_count_q;
    pool_base_d   = pool_base_q;
    new_count     = eff_n;
    state_d       = state_q;
    free_count_d  = free_count_q;
    clr_idx_d     = clr_idx_q;
    rd_idx_d      = rd_idx_q;
    chk_idx_d     = chk_idx_q;
    chk_vld_d     = chk_vld_q;
    acc_addr_d    = acc_addr_q;
    q_idx_d       = q_idx_q;
    res_status_d  = res_status_q;
    res_addr_d    = res_addr_q;
    res_idx_d     = res_idx_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    map_we        = 1'b0;
    map_waddr     = clr_idx_q;
    map_wdata     = 1'b0;
    div_start     = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_idx_q;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == IDX_W'(MAX_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          res_status_d = ST_OK;
          res_addr_d   = '0;
          res_idx_d    = '0;
          if (in_i.func == FUNC_ALLOC) begin
            if (eff_n == '0) begin
              res_status_d = ST_FULL;
              state_d      = S_RESP;
            end else begin
              rd_idx_d   = '0;
              chk_vld_d  = 1'b0;
              acc_addr_d = pool_base_q;
              state_d    = S_SCAN;
            end
          end else if (in_i.free_address < pool_base_q) begin
            res_status_d = ST_RANGE;
            state_d      = S_RESP;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_SCAN: begin
        // read issued at rd_idx, data of chk_idx examined in the following cycle
        if (rd_idx_q < eff_n) begin
          rd_idx_d  = rd_idx_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q[IDX_W-1:0];
        end else begin
          chk_vld_d = 1'b0;
        end
        if (chk_vld_q) begin
          if (!map_rdata_q) begin
            map_we     = 1'b1;
            map_waddr  = chk_idx_q;
            map_wdata  = 1'b1;
            res_idx_d  = chk_idx_q;
            res_addr_d = acc_addr_q;
            if (free_count_q != '0) begin
              free_count_d = free_count_q - 1'b1;
            end
            state_d = S_RESP;
          end else begin
            acc_addr_d = acc_addr_q + ADDR_W'(eff_size);
            if (CNT_W'(chk_idx_q) + 1'b1 == eff_n) begin
              res_status_d = ST_FULL;
              state_d      = S_RESP;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (div_quot >= ADDR_W'(eff_n)) begin
            res_status_d = ST_RANGE;
            state_d      = S_RESP;
          end else begin
            // map read of the quotient index is issued this cycle
            q_idx_d = div_quot[IDX_W-1:0];
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        res_idx_d = q_idx_q;
        if (!map_rdata_q) begin
          res_status_d = ST_NOTUSED;
        end else begin
          map_we    = 1'b1;
          map_waddr = q_idx_q;
          map_wdata = 1'b0;
          if (free_count_q < eff_n) begin
            free_count_d = free_count_q + 1'b1;
          end
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.ok            = (res_status_q == ST_OK);
          out_d.status        = res_status_q;
          out_d.block_address = res_addr_q;
          out_d.block_index   = res_idx_q;
          out_d.blocks_free   = free_count_q;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase

    // configuration; size or count write restarts the pool
    if (cfg_fire) begin
      unique case (cfg_index_i)
        CFG_BLOCK_SIZE: begin
          block_size_d = cfg_data_i[SIZE_W-1:0];
          free_count_d = eff_n;
          clr_idx_d    = '0;
          state_d      = S_CLEAR;
        end
        CFG_BLOCK_COUNT: begin
          block_count_d = cfg_data_i[CNT_W-1:0];
          new_count     = (cfg_data_i[CNT_W-1:0] > CNT_W'(MAX_BLOCKS)) ?
                          CNT_W'(MAX_BLOCKS) : cfg_data_i[CNT_W-1:0];
          free_count_d  = new_count;
          clr_idx_d     = '0;
          state_d       = S_CLEAR;
        end
        CFG_POOL_BASE: begin
          pool_base_d = cfg_data_i[ADDR_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      block_size_q  <= SIZE_W'(1);
      block_count_q <= CNT_W'(MAX_BLOCKS);
      pool_base_q   <= '0;
      free_count_q  <= CNT_W'(MAX_BLOCKS);
      clr_idx_q     <= '0;
      rd_idx_q      <= '0;
      chk_vld_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      block_size_q  <= block_size_d;
      block_count_q <= block_count_d;
      pool_base_q   <= pool_base_d;
      free_count_q  <= free_count_d;
      clr_idx_q     <= clr_idx_d;
      rd_idx_q      <= rd_idx_d;
      chk_vld_q     <= chk_vld_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q    <= chk_idx_d;
    acc_addr_q   <= acc_addr_d;
    q_idx_q      <= q_idx_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_idx_q    <= res_idx_d;
    out_q        <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_q[map_waddr] <= map_wdata;
    end
    map_rdata_q <= map_q[map_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `BBA_ASSERT(a_free_count_bound, free_count_q <= eff_n)
  `BBA_NEXT(a_one_request, in_valid_i && in_ready_o, !in_ready_o)
  `BBA_IMPLY(a_ok_matches_status, out_valid_o, out_o.ok == (out_o.status == ST_OK))
  `BBA_IMPLY(a_fail_zero_addr, out_valid_o && !out_o.ok, out_o.block_address == '0)

endmodule
